// File: sv/bpe_pkg.sv
//------------------------------------------------------------------------------
// bpe_pkg
// Shared types, constants and helpers for the buzzer pattern engine.
//------------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

	localparam int unsigned SEL_W   = 4;
	localparam int unsigned DUTY_W  = 7;
	localparam int unsigned PHASE_W = 15;
	localparam int unsigned ELAP_W  = 8;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned PROD_W  = 17;  // peak (<=100) times ramp offset (<1000)
	localparam int unsigned RECIP_W = 18;

	// Register indexes on the configuration port
	typedef enum logic [IDX_W-1:0] {
		REG_PATTERN_SELECT = 2'd0,
		REG_PATTERN_DUTY   = 2'd1,
		REG_MANUAL_ENABLE  = 2'd2,
		REG_MANUAL_DUTY    = 2'd3
	} reg_idx_t;

	// Pattern codes
	typedef enum logic [SEL_W-1:0] {
		PAT_OFF      = 4'd0,
		PAT_STEADY   = 4'd1,
		PAT_TEMPORAL = 4'd2,
		PAT_BEEPBEEP = 4'd3,
		PAT_ONOFF    = 4'd4,
		PAT_CHIRP    = 4'd5,
		PAT_CHIRP30  = 4'd6,
		PAT_FAULT    = 4'd7,
		PAT_RAMP     = 4'd8
	} pattern_t;

	localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
	localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd70;

	// Cycle lengths, ms
	localparam logic [PHASE_W-1:0] CYC_TEMPORAL = 15'd4500;
	localparam logic [PHASE_W-1:0] CYC_BEEP     = 15'd1000;
	localparam logic [PHASE_W-1:0] CYC_ONOFF    = 15'd1000;
	localparam logic [PHASE_W-1:0] CYC_CHIRP    = 15'd2000;
	localparam logic [PHASE_W-1:0] CYC_CHIRP30  = 15'd30000;
	localparam logic [PHASE_W-1:0] CYC_FAULT    = 15'd5000;
	localparam logic [PHASE_W-1:0] CYC_RAMP     = 15'd2000;

	// Pattern edges, ms
	localparam logic [PHASE_W-1:0] T_60   = 15'd60;
	localparam logic [PHASE_W-1:0] T_100  = 15'd100;
	localparam logic [PHASE_W-1:0] T_200  = 15'd200;
	localparam logic [PHASE_W-1:0] T_300  = 15'd300;
	localparam logic [PHASE_W-1:0] T_500  = 15'd500;
	localparam logic [PHASE_W-1:0] T_1000 = 15'd1000;
	localparam logic [PHASE_W-1:0] T_1500 = 15'd1500;
	localparam logic [PHASE_W-1:0] T_2000 = 15'd2000;
	localparam logic [PHASE_W-1:0] T_2500 = 15'd2500;

	// floor(x/1000) == (x * 134218) >> 27 for every x < 100000
	localparam logic [RECIP_W-1:0] RAMP_RECIP = 18'd134218;
	localparam int unsigned        RAMP_SHIFT = 27;

	function automatic logic [PHASE_W-1:0] cycle_len(input logic [SEL_W-1:0] sel);
		logic [PHASE_W-1:0] c;
		begin
			unique case (sel)
				PAT_TEMPORAL: c = CYC_TEMPORAL;
				PAT_BEEPBEEP: c = CYC_BEEP;
				PAT_ONOFF:    c = CYC_ONOFF;
				PAT_CHIRP:    c = CYC_CHIRP;
				PAT_CHIRP30:  c = CYC_CHIRP30;
				PAT_FAULT:    c = CYC_FAULT;
				PAT_RAMP:     c = CYC_RAMP;
				default:      c = '0;
			endcase
			return c;
		end
	endfunction

	function automatic logic [DUTY_W-1:0] sat100(input logic [DUTY_W-1:0] v);
		return (v > DUTY_MAX) ? DUTY_MAX : v;
	endfunction

endpackage

`default_nettype wire

// File: sv/buzzer_pattern_engine_unit.sv
//------------------------------------------------------------------------------
// buzzer_pattern_engine_unit
// Millisecond-driven buzzer pattern sequencer: phase counter, gate and duty.
//------------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  in       | in_valid / in_stall       | elapsed_ms[7:0]
//  out      | out_valid / out_stall     | gate_on, duty_percent_out[6:0],
//           |                           | write_strobe
//  cfg      | cfg_we (no wait)          | cfg_index[1:0], cfg_data[6:0]
//
//  One request accepted per cycle while in_stall is low; three register stages.
//  The depth is set by the ramp duty path: offset product, then a reciprocal
//  multiply by 1/1000, each behind its own register.
//  Each stage loads when empty or when the stage after it moves, so bubbles
//  close up; input flows while a result waits at the output, until s1/s2 fill.
//  Reset clears phase, last gate/duty, valids and the registers (duty 70).
//------------------------------------------------------------------------------
`default_nettype none

module buzzer_pattern_engine_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// requests
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [bpe_pkg::ELAP_W-1:0]   elapsed_ms,
	// results
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              gate_on,
	output logic [bpe_pkg::DUTY_W-1:0]        duty_percent_out,
	output logic                              write_strobe,
	// configuration
	input  wire logic                         cfg_we,
	input  wire logic [bpe_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [bpe_pkg::DUTY_W-1:0]   cfg_data
);

	localparam int unsigned DW = bpe_pkg::DUTY_W;
	localparam int unsigned PW = bpe_pkg::PHASE_W;
	localparam int unsigned RW = bpe_pkg::RECIP_W;
	localparam int unsigned XW = bpe_pkg::PROD_W;
	localparam int unsigned QW = XW + RW;

	// Configuration registers
	logic [bpe_pkg::SEL_W-1:0] pattern_select_q;
	logic [DW-1:0]             pattern_duty_q;
	logic                      manual_enable_q;
	logic [DW-1:0]             manual_duty_q;

	// State
	logic [PW-1:0] phase_q;
	logic          last_gate_q;
	logic [DW-1:0] last_duty_q;

	// Pipeline
	logic          valid_s1, valid_s2, valid_s3;
	logic [PW-1:0] phase_s1;
	logic          gate_s2, ramp_s2, fall_s2;
	logic [DW-1:0] duty_s2;
	logic [XW-1:0] prod_s2;
	logic          gate_s3, strobe_s3;
	logic [DW-1:0] duty_s3;

	logic en1, en2, en3, accept;

	// Stage enables: a stage loads when empty or when its successor loads
	assign en3    = !valid_s3 || !out_stall;
	assign en2    = !valid_s2 || en3;
	assign en1    = !valid_s1 || en2;
	assign in_stall = !en1;
	assign accept = in_valid && en1;

	//------------------------------------------------------------------
	// Configuration write port
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_select_q <= bpe_pkg::PAT_OFF;
			pattern_duty_q   <= bpe_pkg::DUTY_RESET;
			manual_enable_q  <= 1'b0;
			manual_duty_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpe_pkg::REG_PATTERN_SELECT: pattern_select_q <= cfg_data[bpe_pkg::SEL_W-1:0];
				bpe_pkg::REG_PATTERN_DUTY:   pattern_duty_q   <= cfg_data;
				bpe_pkg::REG_MANUAL_ENABLE:  manual_enable_q  <= cfg_data[0];
				bpe_pkg::REG_MANUAL_DUTY:    manual_duty_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Phase update at accept. Phase stays below the cycle and elapsed is
	// far below the shortest cycle, so one conditional subtract wraps it.
	//------------------------------------------------------------------
	logic [PW-1:0] cyc;
	logic [PW:0]   phase_sum;
	logic [PW-1:0] phase_nxt;

	always_comb begin
		cyc       = bpe_pkg::cycle_len(pattern_select_q);
		phase_sum = {1'b0, phase_q} + (PW+1)'(elapsed_ms);
		if (cyc == '0)
			phase_nxt = '0;
		else if (phase_sum >= {1'b0, cyc})
			phase_nxt = PW'(phase_sum - {1'b0, cyc});
		else
			phase_nxt = PW'(phase_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cfg_we && cfg_index == bpe_pkg::REG_PATTERN_SELECT) begin
			phase_q <= '0;  // any pattern select write restarts the cycle
		end else if (accept) begin
			phase_q <= phase_nxt;
		end
	end

	//------------------------------------------------------------------
	// Stage 1: new phase
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			phase_s1 <= phase_nxt;
		end
	end

	//------------------------------------------------------------------
	// Stage 2: pattern decode, ramp offset product
	//------------------------------------------------------------------
	logic [DW-1:0] pd;
	logic          on, gate_c, ramp_c, fall_c;
	logic [DW-1:0] duty_c;
	logic [PW-1:0] m;
	logic [PW-1:0] r;

	always_comb begin
		m      = phase_s1;
		pd     = bpe_pkg::sat100(pattern_duty_q);
		on     = 1'b0;
		gate_c = 1'b0;
		duty_c = '0;
		ramp_c = 1'b0;
		fall_c = (m >= bpe_pkg::T_1000);
		r      = fall_c ? (m - bpe_pkg::T_1000) : m;
		unique case (pattern_select_q)
			bpe_pkg::PAT_OFF: begin
				gate_c = manual_enable_q;
				duty_c = manual_enable_q ? bpe_pkg::sat100(manual_duty_q) : '0;
			end
			bpe_pkg::PAT_STEADY: begin
				on = 1'b1;
			end
			bpe_pkg::PAT_TEMPORAL: begin
				on = (m < bpe_pkg::T_500)
				  || (m >= bpe_pkg::T_1000 && m < bpe_pkg::T_1500)
				  || (m >= bpe_pkg::T_2000 && m < bpe_pkg::T_2500);
			end
			bpe_pkg::PAT_BEEPBEEP, bpe_pkg::PAT_FAULT: begin
				on = (m < bpe_pkg::T_100) || (m >= bpe_pkg::T_200 && m < bpe_pkg::T_300);
			end
			bpe_pkg::PAT_ONOFF: begin
				on = (m < bpe_pkg::T_500);
			end
			bpe_pkg::PAT_CHIRP, bpe_pkg::PAT_CHIRP30: begin
				on = (m < bpe_pkg::T_60);
			end
			bpe_pkg::PAT_RAMP: begin
				gate_c = 1'b1;
				ramp_c = 1'b1;
			end
			default: ;  // unknown selector: silent
		endcase
		if (on) begin
			gate_c = 1'b1;
			duty_c = pd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			gate_s2 <= gate_c;
			duty_s2 <= duty_c;
			ramp_s2 <= ramp_c;
			fall_s2 <= fall_c;
			prod_s2 <= XW'(XW'(pd) * XW'(r));
		end
	end

	//------------------------------------------------------------------
	// Stage 3: divide by 1000, ramp duty, change strobe
	//------------------------------------------------------------------
	logic [QW-1:0] recip_prod;
	logic [DW-1:0] q;
	logic [DW-1:0] duty_f;
	logic          gate_f;

	always_comb begin
		recip_prod = QW'(prod_s2) * QW'(bpe_pkg::RAMP_RECIP);
		q          = DW'(recip_prod >> bpe_pkg::RAMP_SHIFT);
		gate_f     = ramp_s2 ? 1'b1 : gate_s2;
		if (ramp_s2)
			duty_f = fall_s2 ? (bpe_pkg::sat100(pattern_duty_q) - q) : q;
		else
			duty_f = duty_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			last_gate_q <= 1'b0;
			last_duty_q <= '0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
			if (valid_s2) begin
				last_gate_q <= gate_f;
				last_duty_q <= duty_f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			gate_s3   <= gate_f;
			duty_s3   <= duty_f;
			strobe_s3 <= (gate_f != last_gate_q) || (duty_f != last_duty_q);
		end
	end

	assign out_valid        = valid_s3;
	assign gate_on          = gate_s3;
	assign duty_percent_out = duty_s3;
	assign write_strobe     = strobe_s3;

	//------------------------------------------------------------------
	// Checks
	//------------------------------------------------------------------
`ifndef NO_ASSERTIONS
	a_duty_zero_when_gate_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gate_on || duty_percent_out == '0))
		else $error("duty nonzero with gate off");

	a_phase_in_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == '0) || (phase_q < bpe_pkg::cycle_len(pattern_select_q)))
		else $error("phase outside cycle");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_stall))
		else $error("input stalled with room in pipeline");

	a_last_tracks_output: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |-> (last_gate_q == gate_on || valid_s2))
		else $error("last gate out of step with delivered result");
`endif

endmodule

`default_nettype wire

// File: tb/buzzer_pattern_engine_unit_test.sv
//------------------------------------------------------------------------------
// buzzer_pattern_engine_unit_test
// Self-checking bench for the buzzer pattern sequencer. A clocked driver takes
// millisecond requests from a queue and a clocked monitor compares every result
// with a cycle-free predictor of phase, gate, duty and write strobe. Registers
// are written only while the pipeline is empty.
//------------------------------------------------------------------------------
`default_nettype none

module buzzer_pattern_engine_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SETTLE_CYCLES = 8;     // pipeline is three deep
	localparam int unsigned HOLD_CYCLES   = 60;    // long output back-pressure
	localparam int unsigned RANDOM_ITEMS  = 950;
	localparam int unsigned SPAN_SHORT    = 50;
	localparam int unsigned SPAN_LONG     = 140;   // long run for the 30 s chirp

	localparam int unsigned DW = bpe_pkg::DUTY_W;
	localparam int unsigned EW = bpe_pkg::ELAP_W;
	localparam int unsigned SW = bpe_pkg::SEL_W;
	localparam int unsigned PW = bpe_pkg::PHASE_W;

	typedef struct packed {
		logic          gate;
		logic [DW-1:0] duty;
		logic          strobe;
	} buzz_result_t;

	// clock, reset and DUT pins
	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic [EW-1:0]               elapsed_ms = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        gate_on;
	logic [DW-1:0]               duty_percent_out;
	logic                        write_strobe;
	logic                        cfg_we    = 1'b0;
	logic [bpe_pkg::IDX_W-1:0]   cfg_index = '0;
	logic [DW-1:0]               cfg_data  = '0;

	// predictor state: registers as written, phase and last applied pair
	logic [SW-1:0]       sel_r;
	logic [DW-1:0]       pat_duty_r;
	logic                man_en_r;
	logic [DW-1:0]       man_duty_r;
	logic [PW-1:0]       phase_r;
	logic                last_gate_r;
	logic [DW-1:0]       last_duty_r;

	// request and result bookkeeping
	logic [EW-1:0]       pending_ms[$];
	buzz_result_t        buzz_expected[$];
	buzz_result_t        want_res;
	int unsigned         items_queued    = 0;
	int unsigned         results_checked = 0;
	int unsigned         failures        = 0;

	// idle rates in percent, and the long hold handshake
	int unsigned         send_idle_pct = 0;
	int unsigned         recv_idle_pct = 0;
	int unsigned         hold_asked    = 0;
	int unsigned         hold_served   = 0;
	int unsigned         hold_left     = 0;

	buzzer_pattern_engine_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.elapsed_ms       (elapsed_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.gate_on          (gate_on),
		.duty_percent_out (duty_percent_out),
		.write_strobe     (write_strobe),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// duty registers above 100 read as 100
	function automatic int unsigned clip_pct(input logic [DW-1:0] v);
		return (v > bpe_pkg::DUTY_MAX) ? int'(bpe_pkg::DUTY_MAX) : int'(v);
	endfunction

	// advance the phase by one request and record what the block must answer
	task automatic advance_buzzer(input logic [EW-1:0] ms);
		int unsigned  span;
		int unsigned  peak;
		int unsigned  m;
		int unsigned  duty;
		logic         gate;
		logic         sounding;
		buzz_result_t res;
		begin
			case (sel_r)
				bpe_pkg::PAT_TEMPORAL: span = int'(bpe_pkg::CYC_TEMPORAL);
				bpe_pkg::PAT_BEEPBEEP: span = int'(bpe_pkg::CYC_BEEP);
				bpe_pkg::PAT_ONOFF:    span = int'(bpe_pkg::CYC_ONOFF);
				bpe_pkg::PAT_CHIRP:    span = int'(bpe_pkg::CYC_CHIRP);
				bpe_pkg::PAT_CHIRP30:  span = int'(bpe_pkg::CYC_CHIRP30);
				bpe_pkg::PAT_FAULT:    span = int'(bpe_pkg::CYC_FAULT);
				bpe_pkg::PAT_RAMP:     span = int'(bpe_pkg::CYC_RAMP);
				default:               span = 0;
			endcase
			// off, steady and unknown codes keep the phase parked at zero
			if (span != 0) begin
				phase_r = PW'((int'(phase_r) + int'(ms)) % span);
			end else begin
				phase_r = '0;
			end
			m        = int'(phase_r);
			peak     = clip_pct(pat_duty_r);
			gate     = 1'b0;
			duty     = 0;
			sounding = 1'b0;
			case (sel_r)
				bpe_pkg::PAT_OFF: begin
					gate = man_en_r;
					duty = man_en_r ? clip_pct(man_duty_r) : 0;
				end
				bpe_pkg::PAT_STEADY: sounding = 1'b1;
				bpe_pkg::PAT_TEMPORAL: begin
					sounding = (m < bpe_pkg::T_500) ||
						(m >= bpe_pkg::T_1000 && m < bpe_pkg::T_1500) ||
						(m >= bpe_pkg::T_2000 && m < bpe_pkg::T_2500);
				end
				bpe_pkg::PAT_BEEPBEEP, bpe_pkg::PAT_FAULT: begin
					sounding = (m < bpe_pkg::T_100) ||
						(m >= bpe_pkg::T_200 && m < bpe_pkg::T_300);
				end
				bpe_pkg::PAT_ONOFF: sounding = (m < bpe_pkg::T_500);
				bpe_pkg::PAT_CHIRP, bpe_pkg::PAT_CHIRP30: sounding = (m < bpe_pkg::T_60);
				bpe_pkg::PAT_RAMP: begin
					gate = 1'b1;
					if (m < bpe_pkg::T_1000) begin
						duty = (peak * m) / 1000;
					end else begin
						duty = peak - (peak * (m - 1000)) / 1000;
					end
				end
				default: ;
			endcase
			if (sounding) begin
				gate = 1'b1;
				duty = peak;
			end
			res.gate   = gate;
			res.duty   = DW'(duty);
			res.strobe = (gate != last_gate_r) || (DW'(duty) != last_duty_r);
			last_gate_r = gate;
			last_duty_r = DW'(duty);
			buzz_expected.push_back(res);
		end
	endtask

	// driver: present the next request when the last one has gone
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				advance_buzzer(elapsed_ms);
			end
			if (!in_valid || !in_stall) begin
				if (pending_ms.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid   <= 1'b1;
					elapsed_ms <= pending_ms.pop_front();
				end else begin
					in_valid   <= 1'b0;
					elapsed_ms <= EW'($urandom);
				end
			end
		end
	end

	// long hold on the output, counted here so the monitor need only look at it
	always @(posedge clk) begin
		if (hold_served != hold_asked) begin
			hold_left   <= HOLD_CYCLES;
			hold_served <= hold_asked;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (buzz_expected.size() == 0) begin
					$error("result with nothing expected: gate_on %0d duty %0d strobe %0d",
						gate_on, duty_percent_out, write_strobe);
					failures++;
				end else begin
					want_res = buzz_expected.pop_front();
					if (gate_on !== want_res.gate) begin
						$error("gate_on: expected %0d, got %0d", want_res.gate, gate_on);
						failures++;
					end
					if (duty_percent_out !== want_res.duty) begin
						$error("duty_percent_out: expected %0d, got %0d",
							want_res.duty, duty_percent_out);
						failures++;
					end
					if (write_strobe !== want_res.strobe) begin
						$error("write_strobe: expected %0d, got %0d",
							want_res.strobe, write_strobe);
						failures++;
					end
					results_checked++;
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// register write; the pipeline is empty whenever this runs
	task automatic write_reg(input bpe_pkg::reg_idx_t idx, input logic [DW-1:0] val);
		begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			case (idx)
				bpe_pkg::REG_PATTERN_SELECT: begin
					sel_r   = val[SW-1:0];
					phase_r = '0;   // any select write restarts the pattern
				end
				bpe_pkg::REG_PATTERN_DUTY:  pat_duty_r = val;
				bpe_pkg::REG_MANUAL_ENABLE: man_en_r   = val[0];
				bpe_pkg::REG_MANUAL_DUTY:   man_duty_r = val;
				default: ;
			endcase
			@(posedge clk);
			cfg_we <= 1'b0;
		end
	endtask

	task automatic queue_item(input logic [EW-1:0] ms);
		begin
			pending_ms.push_back(ms);
			items_queued++;
		end
	endtask

	// wait for every result, then let the pipeline run dry
	task automatic settle();
		begin
			while (results_checked != items_queued) begin
				@(posedge clk);
			end
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	// duty values lean on the extremes and on the saturating range
	function automatic logic [DW-1:0] pick_duty();
		int unsigned r;
		begin
			r = $urandom_range(99);
			if (r < 15) begin
				return '0;
			end else if (r < 30) begin
				return bpe_pkg::DUTY_MAX;
			end else if (r < 45) begin
				return DW'($urandom_range(127, 101));
			end
			return DW'($urandom_range(100));
		end
	endfunction

	// step sizes; the long pattern mostly gets big steps (200 to 255 ms)
	function automatic logic [EW-1:0] pick_ms(input bit long_span);
		int unsigned r;
		begin
			r = $urandom_range(99);
			if (long_span && r < 80) begin
				return EW'($urandom_range(255, 200));
			end else if (r < 10) begin
				return '0;
			end else if (r < 20) begin
				return 8'd255;
			end
			return EW'($urandom);
		end
	endfunction

	initial begin
		int unsigned         random_done;
		int unsigned         seg;
		int unsigned         span;
		int unsigned         r;
		logic [SW-1:0]       sel;
		bit                  pressure_done;
		bpe_pkg::pattern_t   quick_pats[5];

		sel_r        = bpe_pkg::PAT_OFF;
		pat_duty_r   = bpe_pkg::DUTY_RESET;
		man_en_r     = 1'b0;
		man_duty_r   = '0;
		phase_r      = '0;
		last_gate_r  = 1'b0;
		last_duty_r  = '0;
		random_done  = 0;
		seg          = 0;
		pressure_done = 1'b0;
		quick_pats   = '{bpe_pkg::PAT_TEMPORAL, bpe_pkg::PAT_ONOFF, bpe_pkg::PAT_CHIRP,
			bpe_pkg::PAT_CHIRP30, bpe_pkg::PAT_FAULT};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed ---
		// reset state: manual mode, gate off
		queue_item(8'd0);
		queue_item(8'd255);
		settle();
		// manual mode with saturating duty, then zero duty
		write_reg(bpe_pkg::REG_MANUAL_ENABLE, 7'd1);
		write_reg(bpe_pkg::REG_MANUAL_DUTY, 7'd127);
		queue_item(8'd1);
		queue_item(8'd0);
		settle();
		write_reg(bpe_pkg::REG_MANUAL_DUTY, 7'd0);
		queue_item(8'd3);
		settle();
		// steady at zero duty: gate on, duty zero
		write_reg(bpe_pkg::REG_PATTERN_DUTY, 7'd0);
		write_reg(bpe_pkg::REG_PATTERN_SELECT, DW'(bpe_pkg::PAT_STEADY));
		queue_item(8'd9);
		settle();
		// beep-beep across each edge, then past the wrap
		write_reg(bpe_pkg::REG_PATTERN_DUTY, bpe_pkg::DUTY_MAX);
		write_reg(bpe_pkg::REG_PATTERN_SELECT, DW'(bpe_pkg::PAT_BEEPBEEP));
		queue_item(8'd99);
		queue_item(8'd1);
		queue_item(8'd100);
		queue_item(8'd99);
		queue_item(8'd1);
		queue_item(8'd255);
		queue_item(8'd255);
		queue_item(8'd255);
		settle();
		// ramp with saturated peak: up to the top, down, and round to zero
		write_reg(bpe_pkg::REG_PATTERN_DUTY, 7'd127);
		write_reg(bpe_pkg::REG_PATTERN_SELECT, DW'(bpe_pkg::PAT_RAMP));
		queue_item(8'd255);
		queue_item(8'd255);
		queue_item(8'd255);
		queue_item(8'd235);
		queue_item(8'd255);
		queue_item(8'd255);
		queue_item(8'd255);
		queue_item(8'd235);
		settle();
		// unknown selector, upper data bits set
		write_reg(bpe_pkg::REG_PATTERN_SELECT, 7'h7C);
		queue_item(8'd200);
		settle();
		// one request on each remaining pattern
		foreach (quick_pats[i]) begin
			write_reg(bpe_pkg::REG_PATTERN_SELECT, DW'(quick_pats[i]));
			queue_item(EW'($urandom));
			settle();
		end

		// --- random segments, each under its own setting ---
		while (random_done < RANDOM_ITEMS) begin
			if (random_done < RANDOM_ITEMS / 3) begin
				send_idle_pct = 16;
				recv_idle_pct = 67;
			end else if (random_done < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 67;
				recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			r = $urandom_range(99);
			if (r < 70) begin
				sel = SW'($urandom_range(bpe_pkg::PAT_RAMP, bpe_pkg::PAT_TEMPORAL));
			end else if (r < 88) begin
				sel = SW'($urandom_range(bpe_pkg::PAT_STEADY, bpe_pkg::PAT_OFF));
			end else begin
				sel = SW'($urandom_range(15, 9));
			end
			// the first seven segments walk the cyclic patterns, temporal to ramp, in turn
			if (seg < 7) begin
				sel = SW'(bpe_pkg::PAT_TEMPORAL + seg);
			end
			if (send_idle_pct == 0 && !pressure_done) begin
				sel = bpe_pkg::PAT_CHIRP30;
			end

			write_reg(bpe_pkg::REG_PATTERN_DUTY, pick_duty());
			write_reg(bpe_pkg::REG_MANUAL_ENABLE, DW'($urandom_range(1)));
			write_reg(bpe_pkg::REG_MANUAL_DUTY, pick_duty());
			write_reg(bpe_pkg::REG_PATTERN_SELECT, {DW'($urandom_range(7)) << SW} | DW'(sel));

			// hold the output long enough that the block backs up its input
			if (send_idle_pct == 0 && !pressure_done) begin
				hold_asked++;
				pressure_done = 1'b1;
			end

			span = (sel == bpe_pkg::PAT_CHIRP30) ? SPAN_LONG : SPAN_SHORT;
			repeat (span) queue_item(pick_ms(sel == bpe_pkg::PAT_CHIRP30));
			random_done += span;
			settle();
			seg++;
		end

		if (buzz_expected.size() != 0) begin
			$error("%0d expected results never arrived", buzz_expected.size());
			failures++;
		end
		if (failures == 0) begin
			$display("buzzer_pattern_engine_unit: match");
		end else begin
			$display("buzzer_pattern_engine_unit: mismatch");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("buzzer_pattern_engine_unit: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
